[hdl/area_average_line_downsampler_defines.svh]
// assertion macros for the checker file
`ifndef AREA_AVERAGE_LINE_DOWNSAMPLER_DEFINES_SVH
`define AREA_AVERAGE_LINE_DOWNSAMPLER_DEFINES_SVH

// property checked at every clock edge, reset included
`define AALD_ASSERT(label, clk, body, msg) \
    label: assert property (@(posedge clk) body) else $error(msg);

// property checked only while out of reset
`define AALD_ASSERT_RST(label, clk, rst_n, body, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) body) else $error(msg);

`endif

[hdl/aald_pkg.sv]
// shared widths, queue entry type and register indexes of the line downsampler
package aald_pkg;

    localparam int PIX_W     = 8;
    localparam int NCH       = 3;
    localparam int SUM_W     = 20;
    localparam int SRC_W     = 13;
    localparam int TGT_W     = 12;
    localparam int FILL_W    = 13;
    localparam int PROD_W    = SRC_W + PIX_W;
    localparam int NUM_W     = SUM_W + 2;
    localparam int DIV_W     = SRC_W + 1;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = SRC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_LEN = 2'd0,
        REG_TGT_LEN = 2'd1
    } t_reg_idx;

    // one closed bin, or one pixel passed through unchanged
    typedef struct packed {
        logic                       bypass;
        logic [NCH-1:0][SUM_W-1:0]  sum;
    } t_bin;

endpackage

[hdl/aald_fifo.sv]
// short queue of closed bins between the accumulator and the divider
module aald_fifo import aald_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_bin i_bin,
    output logic o_full,
    input  logic i_pop,
    output t_bin o_bin,
    output logic o_empty
);

    t_bin              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_bin   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bin;
        end
    end

endmodule

[hdl/aald_front.sv]
// pixel intake: bin fill tracking, weighting and channel accumulation
module aald_front import aald_pkg::*; #(
    parameter int unsigned MAX_LINE = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [SRC_W-1:0] i_src_len,
    input  logic [TGT_W-1:0] i_tgt_len,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic             i_q_full,
    output logic             o_push,
    output t_bin             o_bin
);

    // stage a: classified pixel
    logic              r_a_vld;
    logic              r_a_byp;
    logic              r_a_emit;
    logic [SRC_W-1:0]  r_a_w;
    logic [FILL_W-1:0] r_a_rest;
    logic [PIX_W-1:0]  r_a_px [NCH];

    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum [NCH];

    logic              byp;
    logic              emit;
    logic [FILL_W:0]   fill_t;
    logic [SRC_W-1:0]  w;
    logic [FILL_W-1:0] rest;
    logic              accept;
    logic              b_needs_q;
    logic              b_fire;
    logic [PROD_W-1:0] prod_a [NCH];
    logic [PROD_W-1:0] prod_r [NCH];
    logic [SUM_W-1:0]  total  [NCH];

    always_comb begin
        byp    = (i_tgt_len == '0) || ({1'b0, i_tgt_len} >= i_src_len)
              || (32'(i_src_len) > MAX_LINE);
        fill_t = {1'b0, r_fill} + {2'b0, i_tgt_len};
        emit   = (fill_t >= {1'b0, i_src_len});
        w      = emit ? (i_src_len - r_fill) : {1'b0, i_tgt_len};
        rest   = emit ? FILL_W'(fill_t - {1'b0, i_src_len}) : '0;
    end

    assign b_needs_q  = r_a_byp || r_a_emit;
    assign b_fire     = r_a_vld && (!b_needs_q || !i_q_full);
    assign o_in_ready = !r_a_vld || b_fire;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = b_fire && b_needs_q;

    // stage b: weight, add, close the bin
    always_comb begin
        o_bin.bypass = r_a_byp;
        for (int c = 0; c < NCH; c++) begin
            prod_a[c]    = {{PIX_W{1'b0}}, r_a_w} * {{SRC_W{1'b0}}, r_a_px[c]};
            prod_r[c]    = {{PIX_W{1'b0}}, r_a_rest} * {{SRC_W{1'b0}}, r_a_px[c]};
            total[c]     = r_sum[c] + prod_a[c][SUM_W-1:0];
            o_bin.sum[c] = r_a_byp ? {{(SUM_W-PIX_W){1'b0}}, r_a_px[c]} : total[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_fill  <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (accept) begin
                r_a_vld <= 1'b1;
            end else if (b_fire) begin
                r_a_vld <= 1'b0;
            end
            if (i_clear) begin
                r_fill <= '0;
            end else if (accept && !byp) begin
                r_fill <= emit ? rest : fill_t[FILL_W-1:0];
            end
            for (int c = 0; c < NCH; c++) begin
                if (i_clear) begin
                    r_sum[c] <= '0;
                end else if (b_fire && !r_a_byp) begin
                    r_sum[c] <= r_a_emit ? prod_r[c][SUM_W-1:0] : total[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_byp   <= byp;
            r_a_emit  <= emit;
            r_a_w     <= w;
            r_a_rest  <= rest;
            r_a_px[0] <= i_red;
            r_a_px[1] <= i_green;
            r_a_px[2] <= i_blue;
        end
    end

endmodule

[hdl/aald_back.sv]
// bin divider: rounded sum / source length per channel, and output register
module aald_back import aald_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SRC_W-1:0] i_src_len,
    input  logic             i_q_empty,
    input  t_bin             i_bin,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num [NCH];
    logic [DIV_W-1:0] r_rem [NCH];
    logic [PIX_W-1:0] r_quo [NCH];
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out [NCH];

    logic [DIV_W-1:0] divisor;
    logic             out_free;
    logic             out_load;
    logic [DIV_W:0]   rem_sh [NCH];
    logic             ge     [NCH];
    logic [DIV_W-1:0] rem_nx [NCH];

    assign divisor     = {i_src_len, 1'b0};
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_q_empty && (!i_bin.bypass || out_free);
    // a new beat enters the output register this cycle
    assign out_load    = ((r_state == ST_IDLE) && !i_q_empty && i_bin.bypass && out_free)
                      || ((r_state == ST_DONE) && out_free);
    assign o_out_valid = r_out_vld;
    assign o_red       = r_out[0];
    assign o_green     = r_out[1];
    assign o_blue      = r_out[2];

    // one restoring step per lane
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            rem_sh[c] = {r_rem[c], r_num[c][NUM_W-1]};
            ge[c]     = (rem_sh[c] >= {1'b0, divisor});
            rem_nx[c] = ge[c] ? DIV_W'(rem_sh[c] - {1'b0, divisor}) : rem_sh[c][DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_bin.bypass) begin
                            if (out_free) begin
                                for (int c = 0; c < NCH; c++) begin
                                    r_out[c] <= i_bin.sum[c][PIX_W-1:0];
                                end
                            end
                        end else begin
                            for (int c = 0; c < NCH; c++) begin
                                r_num[c] <= {1'b0, i_bin.sum[c], 1'b0}
                                          + {{(NUM_W-SRC_W){1'b0}}, i_src_len};
                                r_rem[c] <= '0;
                            end
                            r_cnt   <= CNT_W'(NUM_W - 1);
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    for (int c = 0; c < NCH; c++) begin
                        r_rem[c] <= rem_nx[c];
                        r_num[c] <= {r_num[c][NUM_W-2:0], 1'b0};
                        r_quo[c] <= {r_quo[c][PIX_W-2:0], ge[c]};
                    end
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        for (int c = 0; c < NCH; c++) begin
                            r_out[c] <= r_quo[c];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/area_average_line_downsampler.sv]
// top level of the area-average line downsampler
//
// input channel: one rgb source pixel per beat (i_in_valid / o_in_ready)
// output channel: one averaged rgb pixel per beat (o_out_valid / i_out_ready)
// config port: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   index 0 source length, index 1 target length; a write to either starts a new line
// lengths not usable (target zero, target not below source, source past
//   MAX_LINE): every pixel comes out unchanged via the queue and output register
// a pixel that closes a bin, when the divider is free, reaches the output
//   through 2 intake stages, the queue, 22 radix-2 divide steps and the
//   output register
// intake takes one pixel per cycle as long as the 4-entry bin queue has room;
//   each closed bin holds the shared 3-lane divider until its result enters
//   the output register, and no new bin starts dividing before then
// outside bypass, pixels that do not close a bin give no output beat
// reset (synchronous, active low): source length 2, target length 1,
//   sums and bin fill cleared, queue and output register empty
// when the receiver stalls the output register holds its beat, the divider
//   waits on its finished result, the queue fills and then o_in_ready drops
module area_average_line_downsampler import aald_pkg::*; #(
    parameter int unsigned MAX_LINE = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_red_in,
    input  logic [PIX_W-1:0]     i_green_in,
    input  logic [PIX_W-1:0]     i_blue_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_red_out,
    output logic [PIX_W-1:0]     o_green_out,
    output logic [PIX_W-1:0]     o_blue_out
);

    logic [SRC_W-1:0] r_src_len;
    logic [TGT_W-1:0] r_tgt_len;
    logic             n_clear;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_bin q_in;
    t_bin q_out;

    // config decode; unknown indexes are dropped without clearing the line
    always_comb begin
        n_clear = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_LEN: n_clear = 1'b1;
                REG_TGT_LEN: n_clear = 1'b1;
                default:     n_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= SRC_W'(2);
            r_tgt_len <= TGT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_LEN: r_src_len <= i_cfg_data[SRC_W-1:0];
                REG_TGT_LEN: r_tgt_len <= i_cfg_data[TGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // intake and accumulation
    aald_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (n_clear),
        .i_src_len  (r_src_len),
        .i_tgt_len  (r_tgt_len),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_red      (i_red_in),
        .i_green    (i_green_in),
        .i_blue     (i_blue_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bin      (q_in)
    );

    // closed bins waiting for the divider
    aald_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_bin   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_bin   (q_out),
        .o_empty (q_empty)
    );

    // rounding divide and output register
    aald_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_len   (r_src_len),
        .i_q_empty   (q_empty),
        .i_bin       (q_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out)
    );

endmodule

[hdl/aald_checker.sv]
// port-level checks of the line downsampler, bound to its top level
`include "area_average_line_downsampler_defines.svh"

module aald_checker import aald_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [PIX_W-1:0]     o_red_out,
    input logic [PIX_W-1:0]     o_green_out,
    input logic [PIX_W-1:0]     o_blue_out
);

    // stalled output beat stays offered
    `AALD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "output beat dropped while stalled")

    // stalled output beat keeps its pixel
    `AALD_ASSERT_RST(a_out_stable, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> ($stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out)), "output pixel changed while stalled")

    // reset empties the output register and frees the intake
    `AALD_ASSERT(a_rst_state, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset did not clear the pipeline")

    // no beat can reach the output sooner than the intake, queue and back stage allow
    `AALD_ASSERT(a_min_latency, i_clk, !i_rst_n |=> !o_out_valid ##1 !o_out_valid ##1 !o_out_valid, "output beat appeared too soon after reset")

endmodule

bind area_average_line_downsampler aald_checker u_aald_checker (.*);
